[design/pca_pkg.sv]
// Shared types and constants for the eigenface projection and nearest-label block.
package pca_pkg;
	localparam int MAX_PIXELS = 1024;
	localparam int MAX_DIM    = 32;
	localparam int MAX_TRAIN  = 256;

	localparam logic [2:0] KIND_MEAN  = 3'd0;
	localparam logic [2:0] KIND_BASIS = 3'd1;
	localparam logic [2:0] KIND_TRAIN = 3'd2;
	localparam logic [2:0] KIND_LABEL = 3'd3;
	localparam logic [2:0] KIND_PIXEL = 3'd4;

	localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
	localparam logic [1:0] REG_DIM_IN_USE  = 2'd1;
	localparam logic [1:0] REG_TRAIN_COUNT = 2'd2;

	localparam logic [61:0] DIST_MAX = {62{1'b1}};

	typedef struct packed {
		logic [2:0]         kind;
		logic [14:0]        slot;
		logic signed [31:0] load_value;
		logic [7:0]         pixel;
		logic               last_pixel;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC_RD,
		ST_MAC,
		ST_SEARCH_RD,
		ST_SEARCH,
		ST_DONE
	} back_state_t;
endpackage

[design/pca_front.sv]
// Front end: takes command transfers, drops unknown kinds, queues items for the back end.
module pca_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  pca_pkg::item_t     item_in,
	output logic               q_valid,
	output pca_pkg::item_t     q_item,
	input  logic               q_pop
);
	import pca_pkg::*;

	localparam int DEPTH = 4;

	item_t      mem_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       push;

	assign busy    = (cnt_q == 3'(DEPTH));
	assign push    = start && !busy && (item_in.kind <= KIND_PIXEL);
	assign q_valid = (cnt_q != 3'd0);
	assign q_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (q_pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(q_pop);
		end
	end
endmodule

[design/pca_back.sv]
// Back end: store loads, per-dimension multiply-accumulate and nearest-vector search.
module pca_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  pca_pkg::item_t q_item,
	output logic           q_pop,
	input  logic [10:0]    pixel_count,
	input  logic [5:0]     dimension_in_use,
	input  logic [8:0]     train_count,
	output logic           res_valid,
	output logic [15:0]    label,
	output logic [7:0]     best_index,
	output logic [61:0]    min_distance,
	output logic           no_training
);
	import pca_pkg::*;

	localparam int PW = $clog2(MAX_PIXELS);
	localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int TW = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;
	localparam int BW = PW + DW;
	localparam int RW = TW + DW;

	logic [15:0]        mean_mem  [MAX_PIXELS];
	logic signed [15:0] basis_mem [MAX_PIXELS*MAX_DIM];
	logic signed [31:0] train_mem [MAX_TRAIN*MAX_DIM];
	logic [15:0]        label_mem [MAX_TRAIN];
	logic signed [31:0] acc_q [MAX_DIM];

	back_state_t state_q, state_d;
	logic [10:0]        pos_q;
	logic [DW:0]        d_q;
	logic [TW:0]        t_q;
	logic [DW:0]        nd;
	logic [TW:0]        nt;
	logic [PW:0]        npix;
	logic [15:0]        mean_rd_q;
	logic signed [15:0] basis_rd_q;
	logic signed [31:0] train_rd_q;
	logic [15:0]        label_rd_q;
	logic signed [17:0] diff_q;
	logic signed [33:0] prod;
	logic signed [40:0] prod_rnd;
	logic signed [33:0] acc_sum;
	logic signed [32:0] err;
	logic [31:0]        err_abs;
	logic [61:0]        sq;
	logic [62:0]        sum_add;
	logic [61:0]        sum_next;
	logic [61:0]        sum_q, best_q;
	logic [TW-1:0]      best_t_q;
	logic               found_q;
	logic [DW-1:0]      d_idx;
	logic [TW-1:0]      t_idx;
	logic               ld;
	logic               mac_en;

	assign nd   = (dimension_in_use > 6'(MAX_DIM)) ? (DW+1)'(MAX_DIM) : (DW+1)'(dimension_in_use);
	assign nt   = (train_count > 9'(MAX_TRAIN)) ? (TW+1)'(MAX_TRAIN) : (TW+1)'(train_count);
	assign npix = (pixel_count > 11'(MAX_PIXELS)) ? (PW+1)'(MAX_PIXELS) : (PW+1)'(pixel_count);
	assign d_idx = d_q[DW-1:0];
	assign t_idx = t_q[TW-1:0];
	assign ld = (state_q == ST_IDLE) && q_valid && (q_item.kind != KIND_PIXEL);
	assign mac_en = (32'(pos_q) < 32'(npix));

	// loads
	always_ff @(posedge clk) begin
		if (ld) begin
			unique case (q_item.kind)
				KIND_MEAN:  if (32'(q_item.slot) < MAX_PIXELS)
					mean_mem[q_item.slot[PW-1:0]] <= q_item.load_value[15:0];
				KIND_BASIS: if (32'(q_item.slot) < MAX_PIXELS*MAX_DIM)
					basis_mem[q_item.slot[BW-1:0]] <= q_item.load_value[15:0];
				KIND_TRAIN: if (32'(q_item.slot) < MAX_TRAIN*MAX_DIM)
					train_mem[q_item.slot[RW-1:0]] <= q_item.load_value;
				KIND_LABEL: if (32'(q_item.slot) < MAX_TRAIN)
					label_mem[q_item.slot[TW-1:0]] <= q_item.load_value[15:0];
				default: ;
			endcase
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		mean_rd_q  <= mean_mem[pos_q[PW-1:0]];
		basis_rd_q <= basis_mem[{pos_q[PW-1:0], d_idx}];
		train_rd_q <= train_mem[{t_idx, d_idx}];
		label_rd_q <= label_mem[best_t_q];
	end

	assign prod     = diff_q * basis_rd_q;
	assign prod_rnd = (41'(prod) + 41'sd16384) >>> 15;
	assign acc_sum  = 34'(acc_q[d_idx]) + 34'(prod_rnd);
	assign err      = 33'(acc_q[d_idx]) - 33'(train_rd_q);
	assign err_abs  = err[32] ? 32'(-err) : err[31:0];
	assign sq       = err_abs[31] ? DIST_MAX : 62'(err_abs * err_abs);
	assign sum_add  = 63'(sum_q) + 63'(sq);
	assign sum_next = (nd == '0) ? 62'd0 : (sum_add[62] ? DIST_MAX : sum_add[61:0]);

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			ST_IDLE: if (q_valid) begin
				if (q_item.kind == KIND_PIXEL) state_d = ST_MAC_RD;
				else q_pop = 1'b1;
			end
			ST_MAC_RD: state_d = ST_MAC;
			ST_MAC: if (!mac_en || d_q + 1'b1 >= nd) begin
				if (q_item.last_pixel) state_d = ST_SEARCH_RD;
				else begin
					state_d = ST_IDLE;
					q_pop = 1'b1;
				end
			end else state_d = ST_MAC_RD;
			ST_SEARCH_RD: state_d = (t_q >= nt) ? ST_DONE : ST_SEARCH;
			ST_SEARCH: state_d = ST_SEARCH_RD;
			ST_DONE: begin
				state_d = ST_IDLE;
				q_pop = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) diff_q <= 18'({q_item.pixel, 8'd0});
		if (state_q == ST_MAC_RD && d_q == '0) diff_q <= diff_q - 18'(mean_rd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			d_q       <= '0;
			t_q       <= '0;
			sum_q     <= '0;
			best_q    <= '0;
			best_t_q  <= '0;
			found_q   <= 1'b0;
			res_valid <= 1'b0;
			for (int i = 0; i < MAX_DIM; i++) acc_q[i] <= '0;
		end else begin
			state_q   <= state_d;
			res_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					d_q <= '0;
					t_q <= '0;
					sum_q <= '0;
					found_q <= 1'b0;
				end
				ST_MAC_RD: ;
				ST_MAC: begin
					if (mac_en && nd != '0) begin
						if (acc_sum > 34'sd2147483647) acc_q[d_idx] <= 32'sh7fffffff;
						else if (acc_sum < -34'sd2147483648) acc_q[d_idx] <= 32'sh80000000;
						else acc_q[d_idx] <= acc_sum[31:0];
					end
					d_q <= (state_d != ST_MAC_RD) ? '0 : d_q + 1'b1;
					if (state_d != ST_MAC_RD && pos_q < 11'd2047) pos_q <= pos_q + 11'd1;
				end
				ST_SEARCH_RD: ;
				ST_SEARCH: begin
					if (d_q + 1'b1 >= nd) begin
						if (!found_q || sum_next < best_q) begin
							best_q   <= sum_next;
							best_t_q <= t_idx;
						end
						found_q <= 1'b1;
						sum_q   <= '0;
						d_q     <= '0;
						t_q     <= t_q + 1'b1;
					end else begin
						sum_q <= sum_next;
						d_q   <= d_q + 1'b1;
					end
				end
				ST_DONE: begin
					res_valid <= 1'b1;
					pos_q <= '0;
					for (int i = 0; i < MAX_DIM; i++) acc_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			label        <= found_q ? label_rd_q : 16'd0;
			best_index   <= found_q ? 8'(best_t_q) : 8'd0;
			min_distance <= found_q ? best_q : 62'd0;
			no_training  <= !found_q;
		end
	end
endmodule

[design/pca_project_nearest_label_core.sv]
// Top level of the eigenface projection and nearest-label block.
// Command channel: an item transfers on a rising edge with start high and
// busy low. Kinds 0..3 load the mean, basis, training and label stores;
// kind 4 is a pixel. A four-entry queue parts the front end from the
// back end; busy rises only when that queue is full.
// Loads are taken in the back end's idle state. A pixel is handled by the single
// shared multiplier walking the kept dimensions (with no dims or past the
// pixel count, nothing is accumulated).
// On the last pixel the search walks every training vector through the single
// train-store read port; afterwards the back end passes ST_SEARCH_RD and ST_DONE,
// and done pulses for one cycle.
// Configuration: cfg_valid/cfg_ready, always ready; index selects the register.
// Reset clears counters, accumulators and queue; stores stay undefined.
// The receiver cannot stall: done marks each result for exactly one cycle.
module pca_project_nearest_label_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [14:0] slot,
	input  logic signed [31:0] load_value,
	input  logic [7:0]  pixel,
	input  logic        last_pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [15:0] label,
	output logic [7:0]  best_index,
	output logic [61:0] min_distance,
	output logic        no_training
);
	import pca_pkg::*;

	item_t       item_in, q_item;
	logic        q_valid, q_pop;
	logic [10:0] pixel_count_q;
	logic [5:0]  dim_q;
	logic [8:0]  train_count_q;

	assign item_in = '{kind: kind, slot: slot, load_value: load_value, pixel: pixel,
		last_pixel: last_pixel};
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= 11'd1024;
			dim_q         <= 6'd32;
			train_count_q <= 9'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PIXEL_COUNT: pixel_count_q <= cfg_data[10:0];
				REG_DIM_IN_USE:  dim_q <= cfg_data[5:0];
				REG_TRAIN_COUNT: train_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	pca_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item_in(item_in),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	pca_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.pixel_count(pixel_count_q), .dimension_in_use(dim_q), .train_count(train_count_q),
		.res_valid(done), .label(label), .best_index(best_index),
		.min_distance(min_distance), .no_training(no_training)
	);
endmodule
